// File: hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker modules.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/hcb_pkg.sv
// -----------------------------------------------------------------------------
// hcb_pkg
// Shared widths and control types of the Huffman code builder.
// -----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    localparam int SYMBOL_W    = 8;
    localparam int IN_WEIGHT_W = 16;
    localparam int CODE_BITS_W = 15;
    localparam int CODE_LEN_W  = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Start pulses from the top-level sequencer to the build and walk units.
    typedef struct packed {
        logic build_start;
        logic walk_start;
    } hcb_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/hcb_ram.sv
// -----------------------------------------------------------------------------
// hcb_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
`default_nettype none

module hcb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/hcb_build.sv
// -----------------------------------------------------------------------------
// hcb_build
// Tree builder: scans free nodes for the two lightest and merges them.
// -----------------------------------------------------------------------------
`default_nettype none

module hcb_build import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 16,
    parameter int NODE_W      = 20
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire hcb_ctrl_t                              ctrl,
    input  wire logic [$clog2(MAX_SYMBOLS+1)-1:0]       n_leaves,
    output logic                                        wt_re,
    output logic      [$clog2(2*MAX_SYMBOLS-1)-1:0]     wt_raddr,
    input  wire logic [NODE_W-1:0]                      wt_rdata,
    output logic                                        wt_we,
    output logic      [$clog2(2*MAX_SYMBOLS-1)-1:0]     wt_waddr,
    output logic      [NODE_W-1:0]                      wt_wdata,
    output logic                                        par_we,
    output logic      [$clog2(2*MAX_SYMBOLS-1)-1:0]     par_waddr,
    output logic      [$clog2(2*MAX_SYMBOLS-1):0]       par_wdata,
    output logic      [2*MAX_SYMBOLS-2:0]               has_parent,
    output logic                                        done
);

    localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);

    localparam logic [1:0] B_IDLE    = 2'd0;
    localparam logic [1:0] B_SCAN    = 2'd1;
    localparam logic [1:0] B_MERGE_B = 2'd2;

    logic [1:0]            state_reg,   state_next;
    logic [IDX_W-1:0]      k_reg,       k_next;
    logic [IDX_W-1:0]      rd_idx_reg,  rd_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  got1_reg,    got1_next;
    logic                  got2_reg,    got2_next;
    logic [IDX_W-1:0]      a_reg,       a_next;
    logic [IDX_W-1:0]      b_reg,       b_next;
    logic [NODE_W-1:0]     wa_reg,      wa_next;
    logic [NODE_W-1:0]     wb_reg,      wb_next;
    logic [NODE_COUNT-1:0] hp_reg,      hp_next;
    logic [CNT_W:0]        n_twice;
    logic [IDX_W-1:0]      last_k;

    assign n_twice    = {n_leaves, 1'b0} - (CNT_W+1)'(2);
    assign last_k     = n_twice[IDX_W-1:0];
    assign has_parent = hp_reg;

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = rd_idx_reg;
        got1_next    = got1_reg;
        got2_next    = got2_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        wa_next      = wa_reg;
        wb_next      = wb_reg;
        hp_next      = hp_reg;
        wt_re        = 1'b0;
        wt_raddr     = rd_idx_reg;
        wt_we        = 1'b0;
        wt_waddr     = k_reg;
        wt_wdata     = wa_reg + wb_reg;
        par_we       = 1'b0;
        par_waddr    = a_reg;
        par_wdata    = {k_reg, 1'b0};
        done         = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (ctrl.build_start)
                begin
                    hp_next     = '0;
                    k_next      = IDX_W'(n_leaves);
                    rd_idx_next = '0;
                    got1_next   = 1'b0;
                    got2_next   = 1'b0;
                    if (n_leaves == CNT_W'(1))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        state_next = B_SCAN;
                    end
                end
            end
            B_SCAN:
            begin
                // issue stage: one weight read per cycle over nodes below k
                if (rd_idx_reg != k_reg)
                begin
                    wt_re        = 1'b1;
                    cmp_vld_next = 1'b1;
                    rd_idx_next  = rd_idx_reg + IDX_W'(1);
                end
                // compare stage: strict compares keep the lowest index on ties
                if (cmp_vld_reg && !hp_reg[cmp_idx_reg])
                begin
                    if (!got1_reg || (wt_rdata < wa_reg))
                    begin
                        if (got1_reg)
                        begin
                            b_next    = a_reg;
                            wb_next   = wa_reg;
                            got2_next = 1'b1;
                        end
                        a_next    = cmp_idx_reg;
                        wa_next   = wt_rdata;
                        got1_next = 1'b1;
                    end
                    else if (!got2_reg || (wt_rdata < wb_reg))
                    begin
                        b_next    = cmp_idx_reg;
                        wb_next   = wt_rdata;
                        got2_next = 1'b1;
                    end
                end
                // scan drained: write the new node and link the left child
                if ((rd_idx_reg == k_reg) && !cmp_vld_reg)
                begin
                    wt_we          = 1'b1;
                    par_we         = 1'b1;
                    hp_next[a_reg] = 1'b1;
                    state_next     = B_MERGE_B;
                end
            end
            B_MERGE_B:
            begin
                par_we         = 1'b1;
                par_waddr      = b_reg;
                par_wdata      = {k_reg, 1'b1};
                hp_next[b_reg] = 1'b1;
                if (k_reg == last_k)
                begin
                    done       = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    k_next      = k_reg + IDX_W'(1);
                    rd_idx_next = '0;
                    got1_next   = 1'b0;
                    got2_next   = 1'b0;
                    state_next  = B_SCAN;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            k_reg       <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            got1_reg    <= 1'b0;
            got2_reg    <= 1'b0;
            hp_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            got1_reg    <= got1_next;
            got2_reg    <= got2_next;
            hp_reg      <= hp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        wa_reg      <= wa_next;
        wb_reg      <= wb_next;
    end

endmodule

`default_nettype wire

// File: hdl/hcb_walk.sv
// -----------------------------------------------------------------------------
// hcb_walk
// Code walker: follows parent links from each leaf and emits its code.
// -----------------------------------------------------------------------------
`default_nettype none

module hcb_walk import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire hcb_ctrl_t                              ctrl,
    input  wire logic [$clog2(MAX_SYMBOLS+1)-1:0]       n_leaves,
    input  wire logic [2*MAX_SYMBOLS-2:0]               has_parent,
    output logic                                        par_re,
    output logic      [$clog2(2*MAX_SYMBOLS-1)-1:0]     par_raddr,
    input  wire logic [$clog2(2*MAX_SYMBOLS-1):0]       par_rdata,
    output logic                                        sym_re,
    output logic      [$clog2(MAX_SYMBOLS)-1:0]         sym_raddr,
    input  wire logic [SYMBOL_W-1:0]                    sym_rdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic      [M_TDATA_W-1:0]                   m_tdata,
    output logic                                        m_tlast,
    output logic                                        done
);

    localparam int IDX_W   = $clog2(2 * MAX_SYMBOLS - 1);
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int LEAF_W  = $clog2(MAX_SYMBOLS);
    localparam int DEPTH_W = (LEAF_W > CODE_LEN_W) ? LEAF_W : CODE_LEN_W;
    localparam int PAD_W   = M_TDATA_W - SYMBOL_W - CODE_BITS_W - CODE_LEN_W;

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_INIT = 3'd1;
    localparam logic [2:0] W_STEP = 3'd2;
    localparam logic [2:0] W_WAIT = 3'd3;
    localparam logic [2:0] W_OUT  = 3'd4;

    logic [2:0]             state_reg,  state_next;
    logic [LEAF_W-1:0]      leaf_reg,   leaf_next;
    logic [IDX_W-1:0]       node_reg,   node_next;
    logic [DEPTH_W-1:0]     len_reg,    len_next;
    logic [CODE_BITS_W-1:0] code_reg,   code_next;
    logic                   ovld_reg,   ovld_next;
    logic [SYMBOL_W-1:0]    osym_reg;
    logic [CODE_BITS_W-1:0] ocode_reg;
    logic [CODE_LEN_W-1:0]  olen_reg;
    logic                   olast_reg;
    logic                   load_out;
    logic                   last_leaf;

    assign last_leaf = (CNT_W'(leaf_reg) + CNT_W'(1)) == n_leaves;
    assign sym_raddr = leaf_reg;
    assign par_raddr = node_reg;

    always_comb
    begin
        state_next = state_reg;
        leaf_next  = leaf_reg;
        node_next  = node_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        sym_re     = 1'b0;
        par_re     = 1'b0;
        load_out   = 1'b0;
        done       = 1'b0;

        case (state_reg)
            W_IDLE:
            begin
                if (ctrl.walk_start)
                begin
                    leaf_next  = '0;
                    state_next = W_INIT;
                end
            end
            W_INIT:
            begin
                sym_re     = 1'b1;
                node_next  = IDX_W'(leaf_reg);
                len_next   = '0;
                code_next  = '0;
                state_next = W_STEP;
            end
            W_STEP:
            begin
                // the root has no parent and ends the walk
                if (has_parent[node_reg])
                begin
                    par_re     = 1'b1;
                    state_next = W_WAIT;
                end
                else
                begin
                    state_next = W_OUT;
                end
            end
            W_WAIT:
            begin
                // low bit of the parent entry marks a right child
                if (par_rdata[0] && (len_reg < DEPTH_W'(CODE_BITS_W)))
                begin
                    code_next[len_reg[CODE_LEN_W-1:0]] = 1'b1;
                end
                len_next   = len_reg + DEPTH_W'(1);
                node_next  = par_rdata[IDX_W:1];
                state_next = W_STEP;
            end
            W_OUT:
            begin
                if (!ovld_reg || m_tready)
                begin
                    load_out = 1'b1;
                    if (last_leaf)
                    begin
                        done       = 1'b1;
                        state_next = W_IDLE;
                    end
                    else
                    begin
                        leaf_next  = leaf_reg + LEAF_W'(1);
                        state_next = W_INIT;
                    end
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovld_next = ovld_reg;
        if (load_out)
        begin
            ovld_next = 1'b1;
        end
        else if (m_tready)
        begin
            ovld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            leaf_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            leaf_reg  <= leaf_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        len_reg  <= len_next;
        code_reg <= code_next;
        if (load_out)
        begin
            osym_reg  <= sym_rdata;
            ocode_reg <= code_reg;
            olen_reg  <= len_reg[CODE_LEN_W-1:0];
            olast_reg <= last_leaf;
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {PAD_W'(0), olen_reg, ocode_reg, osym_reg};
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

// File: hdl/huffman_code_builder.sv
// -----------------------------------------------------------------------------
// huffman_code_builder
// Loads symbol/weight pairs, builds a Huffman tree and emits one code per leaf.
// -----------------------------------------------------------------------------
// Requests on the slave side carry one symbol and its weight; tlast closes the
// set. Up to MAX_SYMBOLS leaves are stored, further requests of a set are
// dropped but their tlast still starts the build. The tree lives in two
// synchronous RAMs: a weight RAM for all 2*MAX_SYMBOLS-1 nodes and a parent
// RAM holding each node's parent index plus a right-child flag. For every new
// node k the builder sweeps the weight RAM over nodes 0..k-1, one read a
// cycle, keeping the two lightest parentless nodes (ties go to the lower
// index); the lighter becomes the left child (bit 0). Parent flags sit in
// flip-flops and are cleared when a build starts, so no clearing pass is
// needed. The walker then follows parent links from each leaf in load order,
// reading one parent RAM entry per tree level, and presents symbol, code
// (root bit most significant, right-aligned) and length on the master side;
// a lone symbol yields length 0. The weight RAM read port paces the build
// scan and parent RAM reads pace the walk. The slave side is held off from
// the closing request until the last code has been taken into the output
// register.
// -----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder import hcb_pkg::*; #(
    parameter int MAX_SYMBOLS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // symbol[7:0], weight[23:8]
    input  wire logic                 s_tlast,   // last_symbol
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // code_symbol[7:0],
                                                 // code_bits[22:8],
                                                 // code_length[26:23], zeros
    output logic                      m_tlast    // last_code
);

    localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
    localparam int LEAF_W     = $clog2(MAX_SYMBOLS);
    localparam int LEAF_WT_W  = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
    localparam int NODE_W     = LEAF_WT_W + $clog2(MAX_SYMBOLS);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg,     n_next;
    hcb_ctrl_t        ctrl_reg,  ctrl_next;

    logic             accept;
    logic             store;

    // build unit ports
    logic              b_wt_re;
    logic [IDX_W-1:0]  b_wt_raddr;
    logic              b_wt_we;
    logic [IDX_W-1:0]  b_wt_waddr;
    logic [NODE_W-1:0] b_wt_wdata;
    logic              b_done;
    logic [NODE_COUNT-1:0] has_parent;

    // RAM ports
    logic              wt_we;
    logic [IDX_W-1:0]  wt_waddr;
    logic [NODE_W-1:0] wt_wdata;
    logic [NODE_W-1:0] wt_rdata;
    logic              par_we;
    logic [IDX_W-1:0]  par_waddr;
    logic [IDX_W:0]    par_wdata;
    logic              par_re;
    logic [IDX_W-1:0]  par_raddr;
    logic [IDX_W:0]    par_rdata;
    logic              sym_re;
    logic [LEAF_W-1:0] sym_raddr;
    logic [SYMBOL_W-1:0] sym_rdata;
    logic              w_done;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    // drop leaves beyond the table but keep their tlast
    assign store    = accept && (count_reg != CNT_W'(MAX_SYMBOLS));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next     = n_reg;
        ctrl_next  = '0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept && s_tlast)
                begin
                    n_next                = store ? (count_reg + CNT_W'(1)) : count_reg;
                    count_next            = '0;
                    ctrl_next.build_start = 1'b1;
                    state_next            = ST_BUILD;
                end
                else if (store)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_BUILD:
            begin
                if (b_done)
                begin
                    ctrl_next.walk_start = 1'b1;
                    state_next           = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (w_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            n_reg     <= '0;
            ctrl_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    // weight RAM write port: leaves while loading, merged nodes while building
    assign wt_we    = store || b_wt_we;
    assign wt_waddr = store ? IDX_W'(count_reg) : b_wt_waddr;
    assign wt_wdata = store ? NODE_W'(s_tdata[SYMBOL_W +: LEAF_WT_W]) : b_wt_wdata;

    hcb_ram #(
        .DATA_W (NODE_W),
        .DEPTH  (NODE_COUNT)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .re    (b_wt_re),
        .raddr (b_wt_raddr),
        .rdata (wt_rdata)
    );

    hcb_ram #(
        .DATA_W (IDX_W + 1),
        .DEPTH  (NODE_COUNT)
    ) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    hcb_ram #(
        .DATA_W (SYMBOL_W),
        .DEPTH  (MAX_SYMBOLS)
    ) u_symbol_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[LEAF_W-1:0]),
        .wdata (s_tdata[SYMBOL_W-1:0]),
        .re    (sym_re),
        .raddr (sym_raddr),
        .rdata (sym_rdata)
    );

    hcb_build #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .NODE_W      (NODE_W)
    ) u_build (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_reg),
        .n_leaves   (n_reg),
        .wt_re      (b_wt_re),
        .wt_raddr   (b_wt_raddr),
        .wt_rdata   (wt_rdata),
        .wt_we      (b_wt_we),
        .wt_waddr   (b_wt_waddr),
        .wt_wdata   (b_wt_wdata),
        .par_we     (par_we),
        .par_waddr  (par_waddr),
        .par_wdata  (par_wdata),
        .has_parent (has_parent),
        .done       (b_done)
    );

    hcb_walk #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_reg),
        .n_leaves   (n_reg),
        .has_parent (has_parent),
        .par_re     (par_re),
        .par_raddr  (par_raddr),
        .par_rdata  (par_rdata),
        .sym_re     (sym_re),
        .sym_raddr  (sym_raddr),
        .sym_rdata  (sym_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .done       (w_done)
    );

endmodule

`default_nettype wire

// File: hdl/hcb_checker.sv
// -----------------------------------------------------------------------------
// hcb_checker
// Port-level assertions for the Huffman code builder, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hcb_checker import hcb_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tlast,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid,
                 "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready,
                 $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `ASSERT_NEXT(a_close_blocks, clk, rst_n, s_tvalid && s_tready && s_tlast, !s_tready,
                 "input taken after closing request")
    // a code other than the last one on the output means the walk is still running
    `ASSERT_NOW(a_emit_blocks, clk, rst_n, m_tvalid && !m_tlast, !s_tready,
                "input taken before set fully emitted")

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
